// ===== sv/nl4_pkg.sv =====
// nl4_pkg: shared types and constants of the opinion matrix block
// used by nl4_ctrl, nl4_dp and norm_l4_opinion_update_top; no dependencies
package nl4_pkg;

  localparam int SIDE_DEF   = 16;
  localparam int IDX_W      = 4;
  localparam int SUM_W      = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP  = 1'd1;

  localparam logic [4:0] SPLIT_RST = 5'd8;
  localparam logic [2:0] FLIP_RST  = 3'd0;

  localparam logic [2:0] FLIP_R0C1   = 3'd0;
  localparam logic [2:0] FLIP_LAST   = 3'd1;
  localparam logic [2:0] FLIP_R0LAST = 3'd2;
  localparam logic [2:0] FLIP_LASTR0 = 3'd3;
  localparam logic [2:0] FLIP_NONE   = 3'd4;

  localparam logic CMD_INIT   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] donor_index;
    logic [IDX_W-1:0] recipient_index;
  } nl4_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] opinion_sum;
    logic                    balanced;
  } nl4_out_t;

  typedef struct packed {
    logic cap_in;
    logic wr_init;
    logic rd_en;
    logic rd_sel_d;
    logic cap_dr;
    logic wr_upd;
    logic chk_rd;
    logic clr_acc;
    logic load_out;
  } nl4_cmd_t;

  typedef struct packed {
    logic is_update;
    logic in_range;
    logic out_free;
  } nl4_sts_t;

endpackage

// ===== sv/nl4_dp.sv =====
// nl4_dp: opinion matrix memory, config registers, row update and balance/sum accumulation
// depends on nl4_pkg; driven by nl4_ctrl
module nl4_dp #(
  parameter int SIDE = nl4_pkg::SIDE_DEF,
  parameter int RW   = $clog2(SIDE)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  nl4_pkg::nl4_in_t                  in_data,
  input  logic                              cfg_we,
  input  logic [nl4_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nl4_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              out_stall,
  output logic                              out_valid,
  output nl4_pkg::nl4_out_t                 out_data,
  input  nl4_pkg::nl4_cmd_t                 cmd,
  input  logic [RW-1:0]                     row_a,
  input  logic [RW-1:0]                     row_b,
  input  logic [RW-1:0]                     wr_row,
  output nl4_pkg::nl4_sts_t                 sts
);
  import nl4_pkg::*;

  localparam int OW = $clog2(SIDE * SIDE + 1);
  localparam logic [SUM_W-1:0] SQ = SUM_W'(SIDE * SIDE);

  logic [SIDE-1:0] mat_mem [SIDE];
  logic [SIDE-1:0] row_vld_r;
  logic [SIDE-1:0] rda_r, rdb_r;
  logic            va_r, vb_r;
  logic [SIDE-1:0] ra, rb;

  logic [4:0]      split_r;
  logic [2:0]      flip_r;
  logic            cmd_r;
  logic [RW-1:0]   d_r, r_r;
  logic            rng_r;
  logic            dr_r;
  logic            chk_r;
  logic [RW-1:0]   jq_r;
  logic            bal_r;
  logic [OW-1:0]   ones_r;
  logic            out_vld_r;
  nl4_out_t        out_data_r;

  logic [RW-1:0]   addr_a;
  logic            we;
  logic [SIDE-1:0] wdata;
  logic [SIDE-1:0] upd_row;
  logic            fresh;
  logic            pair_ok;
  logic [SUM_W-1:0] ones_w;

  function automatic logic [SIDE-1:0] init_row(input logic [RW-1:0] k,
                                               input logic [4:0]    split,
                                               input logic [2:0]    flip);
    logic [SIDE-1:0] first;
    logic [SIDE-1:0] row;
    first = '0;
    for (int c = 0; c < SIDE; c++) begin
      first[c] = (8'(c) < 8'(split));
    end
    row = (8'(k) < 8'(split)) ? first : ~first;
    case (flip)
      FLIP_R0C1: begin
        if (k == RW'(0)) row[1] = ~row[1];
      end
      FLIP_LAST: begin
        if (k == RW'(SIDE - 1)) row[SIDE-2] = ~row[SIDE-2];
      end
      FLIP_R0LAST: begin
        if (k == RW'(0)) row[SIDE-1] = ~row[SIDE-1];
      end
      FLIP_LASTR0: begin
        if (k == RW'(SIDE - 1)) row[0] = ~row[0];
      end
      default: begin
      end
    endcase
    return row;
  endfunction

  // rows never written read as all +1
  assign ra = va_r ? rda_r : '1;
  assign rb = vb_r ? rdb_r : '1;

  assign addr_a = cmd.rd_sel_d ? d_r : row_a;

  // new view of the donor for the row held on port a
  assign fresh   = (ra[d_r] & dr_r & ~ra[r_r]) | ~(ra[r_r] ^ dr_r);
  always_comb begin
    upd_row       = ra;
    upd_row[d_r]  = fresh;
  end

  assign we    = cmd.wr_init | cmd.wr_upd;
  assign wdata = cmd.wr_init ? init_row(wr_row, split_r, flip_r) : upd_row;

  assign pair_ok = ((ra ^ rb) == (ra[jq_r] ? {SIDE{1'b0}} : {SIDE{1'b1}}));
  assign ones_w  = SUM_W'(ones_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mat_mem[wr_row] <= wdata;
    end
    if (cmd.rd_en) begin
      rda_r <= mat_mem[addr_a];
      rdb_r <= mat_mem[row_b];
      va_r  <= row_vld_r[addr_a];
      vb_r  <= row_vld_r[row_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      split_r   <= SPLIT_RST;
      flip_r    <= FLIP_RST;
      chk_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (we) begin
        row_vld_r[wr_row] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPLIT: split_r <= cfg_data;
          CFG_FLIP:  flip_r  <= cfg_data[2:0];
          default: begin
          end
        endcase
      end
      chk_r <= cmd.chk_rd;
      if (cmd.load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      cmd_r <= in_data.command;
      d_r   <= RW'(in_data.donor_index);
      r_r   <= RW'(in_data.recipient_index);
      rng_r <= (8'(in_data.donor_index) < 8'(SIDE)) &&
               (8'(in_data.recipient_index) < 8'(SIDE));
    end
    if (cmd.cap_dr) begin
      dr_r <= ra[r_r];
    end
    jq_r <= row_b;
    if (cmd.clr_acc) begin
      bal_r  <= 1'b1;
      ones_r <= '0;
    end else if (chk_r) begin
      bal_r  <= bal_r & pair_ok;
      ones_r <= ones_r + OW'(ra[jq_r]);
    end
    if (cmd.load_out) begin
      out_data_r.opinion_sum <= (ones_w << 1) - SQ;
      out_data_r.balanced    <= bal_r;
    end
  end

  assign sts.is_update = (cmd_r == CMD_UPDATE);
  assign sts.in_range  = rng_r;
  assign sts.out_free  = !out_vld_r || !out_stall;

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/nl4_ctrl.sv =====
// nl4_ctrl: sequencer for init load, column update and balance pair walk
// depends on nl4_pkg; drives nl4_dp
module nl4_ctrl #(
  parameter int SIDE = nl4_pkg::SIDE_DEF,
  parameter int RW   = $clog2(SIDE)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  nl4_pkg::nl4_sts_t sts,
  output nl4_pkg::nl4_cmd_t cmd,
  output logic [RW-1:0]     row_a,
  output logic [RW-1:0]     row_b,
  output logic [RW-1:0]     wr_row
);
  import nl4_pkg::*;

  localparam int CW = $clog2(SIDE + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_UDR  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_TAIL = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] i_r, i_nxt;
  logic [RW-1:0] j_r, j_nxt;
  logic [CW-1:0] cnt_m1;

  assign cnt_m1 = cnt_r - CW'(1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cmd       = '0;
    row_a     = cnt_r[RW-1:0];
    row_b     = cnt_r[RW-1:0];
    wr_row    = cnt_r[RW-1:0];
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        cnt_nxt = '0;
        i_nxt   = '0;
        j_nxt   = '0;
        if (!sts.is_update) begin
          state_nxt = S_INIT;
        end else if (sts.in_range) begin
          state_nxt = S_UDR;
        end else begin
          cmd.clr_acc = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_INIT: begin
        cmd.wr_init = 1'b1;
        cnt_nxt     = cnt_r + CW'(1);
        if (cnt_r == CW'(SIDE - 1)) begin
          cmd.clr_acc = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_UDR: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel_d = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_UPD;
      end
      S_UPD: begin
        wr_row  = cnt_m1[RW-1:0];
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == '0) begin
          cmd.cap_dr = 1'b1;
        end else begin
          cmd.wr_upd = 1'b1;
        end
        if (cnt_r == CW'(SIDE)) begin
          cmd.clr_acc = 1'b1;
          state_nxt   = S_CHK;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      S_CHK: begin
        cmd.rd_en  = 1'b1;
        cmd.chk_rd = 1'b1;
        row_a      = i_r;
        row_b      = j_r;
        j_nxt      = j_r + RW'(1);
        if (j_r == RW'(SIDE - 1)) begin
          j_nxt = '0;
          i_nxt = i_r + RW'(1);
          if (i_r == RW'(SIDE - 1)) begin
            state_nxt = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

// ===== sv/norm_l4_opinion_update_top.sv =====
// Opinion matrix block under the L4 assessment rule: one transaction in, one
// result out. The time from accept to result is set mostly by the balance check,
// which walks every row pair, one pair per cycle, through the two read ports of
// the matrix memory while summing the entries; the column update itself walks
// the rows once, and an update with an index out of range skips it. One
// transaction is in work at a time; a finished result waits in the output
// register while the next one is accepted.
// Depends on nl4_pkg, nl4_ctrl and nl4_dp.
module norm_l4_opinion_update_top #(
  parameter int SIDE = nl4_pkg::SIDE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  nl4_pkg::nl4_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output nl4_pkg::nl4_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [nl4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nl4_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nl4_pkg::*;

  localparam int RW = $clog2(SIDE);

  nl4_cmd_t      cmd;
  nl4_sts_t      sts;
  logic [RW-1:0] row_a, row_b, wr_row;

  nl4_ctrl #(
    .SIDE (SIDE),
    .RW   (RW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .row_a    (row_a),
    .row_b    (row_b),
    .wr_row   (wr_row)
  );

  nl4_dp #(
    .SIDE (SIDE),
    .RW   (RW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .row_a     (row_a),
    .row_b     (row_b),
    .wr_row    (wr_row),
    .sts       (sts)
  );

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for norm_l4_opinion_update_top; keeps its own copy of the
// opinion matrix and registers and checks the opinion sum and balance flag of each
// transaction. Depends on nl4_pkg and norm_l4_opinion_update_top.
module tb;
  import nl4_pkg::*;

  localparam int SIDE = SIDE_DEF;
  localparam int TAIL_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1950;

  localparam logic [2:0] FLIP_SPARE_A = 3'd5;
  localparam logic [2:0] FLIP_SPARE_B = 3'd6;
  localparam logic [2:0] FLIP_SPARE_C = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  nl4_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  nl4_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SPLIT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [SIDE-1:0] opinions [SIDE];
  logic [4:0]      split_reg;
  logic [2:0]      flip_reg;
  nl4_out_t        due_tallies [$];
  int              mismatches = 0;
  int              gap_before_next = 0;
  bit              calm = 1'b0;

  norm_l4_opinion_update_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void load_clusters();
    logic [SIDE-1:0] first_mask;
    first_mask = '0;
    for (int k = 0; k < SIDE; k++) begin
      if (k < split_reg) first_mask[k] = 1'b1;
    end
    for (int k = 0; k < SIDE; k++) begin
      opinions[k] = (k < split_reg) ? first_mask : ~first_mask;
    end
    case (flip_reg)
      FLIP_R0C1:   opinions[0][1] = ~opinions[0][1];
      FLIP_LAST:   opinions[SIDE-1][SIDE-2] = ~opinions[SIDE-1][SIDE-2];
      FLIP_R0LAST: opinions[0][SIDE-1] = ~opinions[0][SIDE-1];
      FLIP_LASTR0: opinions[SIDE-1][0] = ~opinions[SIDE-1][0];
      default: ;
    endcase
  endfunction

  // every observer reassesses the donor from the old matrix, then column d is rewritten
  function automatic void reassess_donor(input logic [IDX_W-1:0] d, input logic [IDX_W-1:0] r);
    logic [SIDE-1:0] fresh;
    logic            dr;
    logic            od;
    logic            orr;
    if (int'(d) >= SIDE || int'(r) >= SIDE) return;
    dr = opinions[d][r];
    for (int o = 0; o < SIDE; o++) begin
      od = opinions[o][d];
      orr = opinions[o][r];
      fresh[o] = (od & dr & ~orr) | ~(orr ^ dr);
    end
    for (int o = 0; o < SIDE; o++) begin
      opinions[o][d] = fresh[o];
    end
  endfunction

  function automatic logic matrix_balanced();
    for (int i = 0; i < SIDE; i++) begin
      for (int j = 0; j < SIDE; j++) begin
        if ((opinions[i] ^ opinions[j]) !== (opinions[i][j] ? {SIDE{1'b0}} : {SIDE{1'b1}}))
          return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic nl4_out_t advance_opinions(input nl4_in_t item);
    nl4_out_t res;
    int       ones;
    int       total;
    if (item.command == CMD_INIT) load_clusters();
    else reassess_donor(item.donor_index, item.recipient_index);
    ones = 0;
    for (int k = 0; k < SIDE; k++) ones += $countones(opinions[k]);
    total = 2 * ones - SIDE * SIDE;
    res.opinion_sum = total[SUM_W-1:0];
    res.balanced = matrix_balanced();
    return res;
  endfunction

  function automatic int draw_wait();
    if (calm) return 0;
    case ($urandom_range(0, 2))
      0: return 0;
      1: return $urandom_range(1, 3);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input nl4_out_t want,
                                        input nl4_out_t got);
    if (mismatches < 10)
      $display("mismatch (%s): expected sum %0d balanced %0b, got sum %0d balanced %0b",
               what, $signed(want.opinion_sum), want.balanced,
               $signed(got.opinion_sum), got.balanced);
    mismatches++;
  endfunction

  task automatic send_item(input nl4_in_t item);
    if (gap_before_next > 0) repeat (gap_before_next) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    due_tallies = {due_tallies, advance_opinions(item)};
    gap_before_next = draw_wait();
    if (gap_before_next > 0) in_valid <= 1'b0;
  endtask

  task automatic send_op(input logic cmd, input logic [IDX_W-1:0] d,
                         input logic [IDX_W-1:0] r);
    nl4_in_t item;
    item.command = cmd;
    item.donor_index = d;
    item.recipient_index = r;
    send_item(item);
  endtask

  task automatic settle();
    if (gap_before_next == 0) in_valid <= 1'b0;
    while (due_tallies.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] split_val,
                            input logic [CFG_DATA_W-1:0] flip_val);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SPLIT;
    cfg_data <= split_val;
    @(posedge clk);
    split_reg = split_val[4:0];
    cfg_index <= CFG_FLIP;
    cfg_data <= flip_val;
    @(posedge clk);
    flip_reg = flip_val[2:0];
    cfg_we <= 1'b0;
  endtask

  task automatic init_then_update(input logic [CFG_DATA_W-1:0] split_val,
                                  input logic [2:0] flip_val, input int d);
    set_config(split_val, CFG_DATA_W'(flip_val));
    send_op(CMD_INIT, IDX_W'(d), IDX_W'(SIDE - 1 - d));
    send_op(CMD_UPDATE, IDX_W'(d), IDX_W'(SIDE - 1 - d));
    settle();
  endtask

  task automatic test_reset_state();
    send_op(CMD_UPDATE, '0, '1);
    send_op(CMD_UPDATE, '1, '0);
    send_op(CMD_INIT, '0, '0);
    settle();
  endtask

  task automatic test_init_patterns();
    init_then_update(5'd0, FLIP_LAST, 0);
    init_then_update(5'd16, FLIP_R0LAST, 15);
    init_then_update(5'd31, FLIP_LASTR0, 3);
    init_then_update(5'd17, FLIP_NONE, 12);
    init_then_update(5'd5, FLIP_SPARE_A, 6);
    init_then_update(5'd1, FLIP_SPARE_B, 9);
    init_then_update(5'd15, FLIP_SPARE_C, 1);
  endtask

  task automatic test_update_extremes();
    set_config(5'd8, CFG_DATA_W'(FLIP_NONE));
    send_op(CMD_INIT, '1, '1);
    send_op(CMD_UPDATE, '0, '0);
    send_op(CMD_UPDATE, '1, '1);
    send_op(CMD_UPDATE, '0, '1);
    send_op(CMD_UPDATE, '1, '0);
    settle();
  endtask

  task automatic test_random_runs();
    int                    issued;
    int                    run_len;
    logic [CFG_DATA_W-1:0] split_val;
    logic [CFG_DATA_W-1:0] flip_val;
    nl4_in_t               item;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 5) == 0) split_val = CFG_DATA_W'($urandom_range(17, 31));
        else split_val = CFG_DATA_W'($urandom_range(0, 16));
        if ($urandom_range(0, 5) == 0) flip_val = CFG_DATA_W'($urandom_range(0, 31));
        else if ($urandom_range(0, 2) == 0) flip_val = CFG_DATA_W'(FLIP_NONE);
        else flip_val = CFG_DATA_W'($urandom_range(0, 7));
        set_config(split_val, flip_val);
      end
      if ($urandom_range(0, 7) != 0) begin
        send_op(CMD_INIT, IDX_W'($urandom), IDX_W'($urandom));
        issued++;
      end
      run_len = $urandom_range(4, 40);
      repeat (run_len) begin
        item.command = ($urandom_range(0, 15) == 0) ? CMD_INIT : CMD_UPDATE;
        item.donor_index = IDX_W'($urandom);
        item.recipient_index = IDX_W'($urandom);
        send_item(item);
        issued++;
      end
      settle();
    end
    calm = 1'b0;
  endtask

  initial begin
    int hold;
    @(posedge clk);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        @(posedge clk);
        while (out_valid !== 1'b1) @(posedge clk);
        repeat (hold - 1) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(out_valid === 1'b1 && out_stall === 1'b0)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    nl4_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_tallies.size() == 0) begin
        flag_mismatch("no transaction pending", '0, out_data);
      end else begin
        want = due_tallies.pop_front();
        if (out_data.opinion_sum !== want.opinion_sum || out_data.balanced !== want.balanced)
          flag_mismatch("wrong fields", want, out_data);
      end
    end
  end

  initial begin
    for (int k = 0; k < SIDE; k++) opinions[k] = '1;
    split_reg = SPLIT_RST;
    flip_reg = FLIP_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_init_patterns();
    test_update_extremes();
    test_random_runs();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_tallies.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
